// ===== hdl/pcrll_pkg.sv =====
// shared types, codes and helpers for the packet clock recovery lock loop
package pcrll_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_RESET  = 2'd1,
    OP_TRACK  = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DISC_THR = 2'd0,
    CFG_MAX_ERR  = 2'd1,
    CFG_STATS_EN = 2'd2
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_START, S_TCHK, S_MLO, S_MHI, S_MSUM, S_MEND,
    S_NT, S_TR1, S_TR2, S_REB, S_POST1, S_POST2, S_EMIT
  } state_e;

  // which product the shared multiplier is working on
  typedef enum logic [1:0] {
    PH_DIV, PH_DECAY, PH_REST, PH_GAIN
  } phase_e;

  localparam int AvgShiftDef = 20;
  localparam int SlewBitsDef = 10;

  // ceil(2^35 / 9): exact floor(x / 9) for any 32-bit x after a shift by 35
  localparam logic [31:0] Div9Mult = 32'd3817748708;
  localparam int          Div9Shift = 35;

  localparam logic [31:0] DiscThrRst = 32'd100000;
  localparam logic [31:0] MaxErrRst  = 32'd100000;

  // two's complement magnitude, the most negative value maps to 2^63
  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? (64'd0 - x) : x;
  endfunction

endpackage

// ===== hdl/packet_clock_recovery_lock_loop.sv =====
// top level of the packet clock recovery lock loop: sequencer and datapath
//
//  channel | direction | transfer condition           | payload
//  in      | input     | in_valid_i  & in_ready_o     | op, arrival, stamp, est, disc, now
//  out     | output    | out_valid_o & out_ready_i    | prediction, flags, loop values, counters
//  cfg     | input     | cfg_valid_i & cfg_ready_o    | register index, write data
//
// a sample takes one of these paths: base set directly, rebase, stamp delta or loop update;
// each constant multiply takes four steps on the shared 32 by 32 multiplier
// other ops are handled in the idle step that takes them; asynchronous active-low reset
// clears all state except the output payload registers
// the next item is taken while a result waits; the block then stalls in its
// last step until the waiting result is transferred
module packet_clock_recovery_lock_loop #(
  parameter int AVG_SHIFT = pcrll_pkg::AvgShiftDef,
  parameter int SLEW_BITS = pcrll_pkg::SlewBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] arrival_time_i,
  input  logic [31:0] pcr_stamp_i,
  input  logic signed [63:0] est_delta_i,
  input  logic        disc_in_i,
  input  logic [63:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] pred_rx_time_o,
  output logic        disc_out_o,
  output logic        tracking_o,
  output logic signed [63:0] correction_o,
  output logic signed [63:0] error_average_o,
  output logic [31:0] explicit_count_o,
  output logic [31:0] implicit_count_o,
  output logic [31:0] backward_count_o,
  output logic [31:0] reset_count_o,
  output logic [31:0] no_actual_count_o,
  output logic signed [63:0] total_adjust_o,
  output logic [31:0] sample_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [63:0] One      = 64'd1 << AVG_SHIFT;
  localparam logic [63:0] DecayRst = One / 64'd20;
  localparam logic [63:0] DecayMul = One - DecayRst;
  localparam logic [63:0] ErrGain  = One / DecayRst;

  pcrll_pkg::state_e state_q, state_d;
  pcrll_pkg::phase_e phase_q;

  // configuration
  logic [31:0] disc_thr_q, max_err_q;
  logic        stats_en_q;

  // loop state
  logic        mode_q, seen_q, pend_q;
  logic [63:0] base_q, last_arr_q, offset_q, err_acc_q, adj_q;
  logic [31:0] last_stamp_q, exp_q, imp_q, past_q, resets_q, noact_q, obs_q;

  // working registers
  logic [63:0] act_q, now_q, est_q, prev_q, delta_q, arr_q, err_q, corr_q, pred_q;
  logic [63:0] opnd_q, tmp_q;
  logic [31:0] pcr_q, k_q;
  logic        disc_q, neg_q;

  // output registers
  logic        ovalid_q;
  logic [63:0] o_pred_q, o_corr_q, o_err_q, o_adj_q;
  logic [31:0] o_exp_q, o_imp_q, o_past_q, o_res_q, o_noact_q, o_obs_q;
  logic        o_disc_q, o_trk_q;

  logic        in_acc, emit_go;
  logic [31:0] mul_a, fwd, back;
  logic [63:0] mul_p, div_d, acc_new, corr_new;

  assign in_ready_o  = (state_q == pcrll_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign emit_go     = !ovalid_q || out_ready_i;

  // wrapped stamp deltas in both directions
  assign fwd  = pcr_q - last_stamp_q;
  assign back = last_stamp_q - pcr_q;

  // ticks*100/9 = ticks*11 + ticks/9
  assign div_d = 64'({opnd_q[31:0], 3'b000}) + 64'({opnd_q[31:0], 1'b0})
               + 64'(opnd_q[31:0]) + (tmp_q >> pcrll_pkg::Div9Shift);
  assign acc_new  = 64'($signed(tmp_q) >>> AVG_SHIFT) + err_q;
  assign corr_new = 64'd0 - 64'($signed(tmp_q) >>> (AVG_SHIFT + SLEW_BITS));

  // shared multiplier
  pcrll_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (k_q),
    .p_o   (mul_p)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcrll_pkg::S_IDLE: begin
        if (in_acc && op_i == pcrll_pkg::OP_SAMPLE) state_d = pcrll_pkg::S_START;
      end
      pcrll_pkg::S_START: begin
        if (!seen_q) state_d = pcrll_pkg::S_POST1;
        else if (!mode_q) state_d = disc_q ? pcrll_pkg::S_POST1 : pcrll_pkg::S_MLO;
        else if (!disc_q) state_d = pcrll_pkg::S_MLO;
        else if (act_q != 64'd0 && last_arr_q != 64'd0) state_d = pcrll_pkg::S_TCHK;
        else state_d = pcrll_pkg::S_TR1;
      end
      pcrll_pkg::S_TCHK: begin
        state_d = (pcrll_pkg::mag64(delta_q) > 64'(disc_thr_q)) ? pcrll_pkg::S_REB
                                                                : pcrll_pkg::S_TR1;
      end
      pcrll_pkg::S_MLO:  state_d = pcrll_pkg::S_MHI;
      pcrll_pkg::S_MHI:  state_d = pcrll_pkg::S_MSUM;
      pcrll_pkg::S_MSUM: state_d = pcrll_pkg::S_MEND;
      pcrll_pkg::S_MEND: begin
        case (phase_q)
          pcrll_pkg::PH_DIV:  state_d = mode_q ? pcrll_pkg::S_TR1 : pcrll_pkg::S_NT;
          pcrll_pkg::PH_GAIN: state_d = pcrll_pkg::S_POST1;
          default:            state_d = pcrll_pkg::S_MLO;
        endcase
      end
      pcrll_pkg::S_NT:  state_d = pcrll_pkg::S_POST1;
      pcrll_pkg::S_TR1: state_d = pcrll_pkg::S_TR2;
      pcrll_pkg::S_TR2: begin
        state_d = (pcrll_pkg::mag64(err_q) < 64'(max_err_q)) ? pcrll_pkg::S_MLO
                                                             : pcrll_pkg::S_REB;
      end
      pcrll_pkg::S_REB:   state_d = pcrll_pkg::S_POST1;
      pcrll_pkg::S_POST1: state_d = pcrll_pkg::S_POST2;
      pcrll_pkg::S_POST2: state_d = pcrll_pkg::S_EMIT;
      pcrll_pkg::S_EMIT: begin
        if (emit_go) state_d = pcrll_pkg::S_IDLE;
      end
      default: state_d = pcrll_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (state_q)
      pcrll_pkg::S_MHI: mul_a = opnd_q[63:32];
      default:          mul_a = opnd_q[31:0];
    endcase
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcrll_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_thr_q <= pcrll_pkg::DiscThrRst;
      max_err_q  <= pcrll_pkg::MaxErrRst;
      stats_en_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pcrll_pkg::CFG_DISC_THR: disc_thr_q <= cfg_data_i;
        pcrll_pkg::CFG_MAX_ERR:  max_err_q  <= cfg_data_i;
        pcrll_pkg::CFG_STATS_EN: stats_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // loop datapath, one step per state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pcrll_pkg::PH_DIV;
      mode_q <= 1'b0; seen_q <= 1'b0; pend_q <= 1'b0;
      base_q <= '0; last_arr_q <= '0; offset_q <= '0; err_acc_q <= '0; adj_q <= '0;
      last_stamp_q <= '0; exp_q <= '0; imp_q <= '0; past_q <= '0;
      resets_q <= '0; noact_q <= '0; obs_q <= '0;
      act_q <= '0; now_q <= '0; est_q <= '0; prev_q <= '0; delta_q <= '0;
      arr_q <= '0; err_q <= '0; corr_q <= '0; pred_q <= '0;
      opnd_q <= '0; tmp_q <= '0; pcr_q <= '0; k_q <= '0;
      disc_q <= 1'b0; neg_q <= 1'b0;
    end else begin
      case (state_q)
        pcrll_pkg::S_IDLE: begin
          if (in_acc) begin
            act_q  <= arrival_time_i;
            now_q  <= now_time_i;
            est_q  <= est_delta_i;
            pcr_q  <= pcr_stamp_i;
            disc_q <= disc_in_i;
            prev_q <= base_q;
            corr_q <= '0;
            delta_q <= '0;
            case (op_i)
              pcrll_pkg::OP_RESET: begin
                mode_q <= 1'b0; seen_q <= 1'b0; pend_q <= 1'b0;
                base_q <= '0; last_stamp_q <= '0; last_arr_q <= '0;
                offset_q <= '0; err_acc_q <= '0;
                exp_q <= '0; imp_q <= '0; past_q <= '0;
                noact_q <= '0; adj_q <= '0; obs_q <= '0;
                resets_q <= resets_q + 32'd1;
              end
              pcrll_pkg::OP_TRACK: pend_q <= 1'b1;
              default: ;
            endcase
          end
        end
        pcrll_pkg::S_START: begin
          if (disc_q) exp_q <= exp_q + 32'd1;
          // stamp delta set-up for the shared multiplier
          opnd_q  <= {32'd0, (fwd < back) ? fwd : back};
          neg_q   <= !(fwd < back);
          k_q     <= pcrll_pkg::Div9Mult;
          phase_q <= pcrll_pkg::PH_DIV;
          if (!seen_q) begin
            seen_q <= 1'b1;
            disc_q <= 1'b1;
            base_q <= (act_q != 64'd0) ? act_q : now_q;
          end else if (!mode_q) begin
            if (disc_q) base_q <= base_q + est_q;
          end else if (disc_q && act_q != 64'd0 && last_arr_q != 64'd0) begin
            delta_q <= act_q - last_arr_q;
          end
        end
        pcrll_pkg::S_MHI: tmp_q <= mul_p;
        pcrll_pkg::S_MSUM: tmp_q <= tmp_q + {mul_p[31:0], 32'd0};
        pcrll_pkg::S_MEND: begin
          case (phase_q)
            pcrll_pkg::PH_DIV: begin
              delta_q <= neg_q ? (64'd0 - div_d) : div_d;
            end
            pcrll_pkg::PH_DECAY: begin
              err_acc_q <= acc_new;
              opnd_q    <= acc_new;
              k_q       <= DecayRst[31:0];
              phase_q   <= pcrll_pkg::PH_REST;
            end
            pcrll_pkg::PH_REST: begin
              corr_q  <= corr_new;
              opnd_q  <= corr_new;
              k_q     <= ErrGain[31:0];
              phase_q <= pcrll_pkg::PH_GAIN;
            end
            default: begin
              err_acc_q <= err_acc_q + tmp_q;
              if (stats_en_q) adj_q <= adj_q + corr_q;
              base_q <= arr_q + corr_q;
            end
          endcase
        end
        pcrll_pkg::S_NT: begin
          if (pcrll_pkg::mag64(delta_q) > 64'(disc_thr_q)) begin
            base_q <= base_q + est_q;
            imp_q  <= imp_q + 32'd1;
            disc_q <= 1'b1;
          end else begin
            base_q <= base_q + delta_q;
          end
        end
        pcrll_pkg::S_TR1: begin
          arr_q <= base_q + delta_q;
          err_q <= (act_q != 64'd0) ? (base_q + delta_q - act_q) : 64'd0;
        end
        pcrll_pkg::S_TR2: begin
          opnd_q  <= err_acc_q;
          k_q     <= DecayMul[31:0];
          phase_q <= pcrll_pkg::PH_DECAY;
        end
        pcrll_pkg::S_REB: begin
          if (!disc_q) begin
            imp_q  <= imp_q + 32'd1;
            disc_q <= 1'b1;
          end
          if (act_q != 64'd0) base_q <= act_q;
          else noact_q <= noact_q + 32'd1;
          err_acc_q <= '0;
        end
        pcrll_pkg::S_POST1: begin
          // never predict backward
          if (base_q < prev_q) begin
            base_q <= prev_q;
            past_q <= past_q + 32'd1;
          end
          last_stamp_q <= pcr_q;
        end
        pcrll_pkg::S_POST2: begin
          if (!mode_q) begin
            pred_q <= base_q;
            if (pend_q) begin
              offset_q   <= (act_q != 64'd0) ? (base_q - act_q) : 64'd0;
              base_q     <= (act_q != 64'd0) ? act_q : base_q;
              last_arr_q <= (act_q != 64'd0) ? act_q : base_q;
              pend_q     <= 1'b0;
              mode_q     <= 1'b1;
            end
          end else begin
            last_arr_q <= act_q;
            pred_q     <= base_q + offset_q;
          end
          if (stats_en_q) obs_q <= obs_q + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == pcrll_pkg::S_EMIT && emit_go) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (state_q == pcrll_pkg::S_EMIT && emit_go) begin
      o_pred_q  <= pred_q;
      o_disc_q  <= disc_q;
      o_trk_q   <= mode_q;
      o_corr_q  <= corr_q;
      o_err_q   <= err_acc_q;
      o_exp_q   <= exp_q;
      o_imp_q   <= imp_q;
      o_past_q  <= past_q;
      o_res_q   <= resets_q;
      o_noact_q <= noact_q;
      o_adj_q   <= adj_q;
      o_obs_q   <= obs_q;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign pred_rx_time_o    = o_pred_q;
  assign disc_out_o        = o_disc_q;
  assign tracking_o        = o_trk_q;
  assign correction_o      = o_corr_q;
  assign error_average_o   = o_err_q;
  assign explicit_count_o  = o_exp_q;
  assign implicit_count_o  = o_imp_q;
  assign backward_count_o  = o_past_q;
  assign reset_count_o     = o_res_q;
  assign no_actual_count_o = o_noact_q;
  assign total_adjust_o    = o_adj_q;
  assign sample_count_o    = o_obs_q;

  // a sample transfer in always starts a busy stretch
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && op_i == pcrll_pkg::OP_SAMPLE |=> !in_ready_o)
    else $error("sequencer took a sample but stayed idle");

  // the last loop product always hands over to the post step
  a_gain_to_post: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pcrll_pkg::S_MEND && phase_q == pcrll_pkg::PH_GAIN
    |=> state_q == pcrll_pkg::S_POST1)
    else $error("loop update did not finish in the post step");

  // tracking mode is left only through a forced reset
  a_mode_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(mode_q) |-> $past(in_acc && op_i == pcrll_pkg::OP_RESET))
    else $error("tracking mode dropped without a forced reset");

  // reset counter moves only on a forced reset
  a_reset_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resets_q != $past(resets_q) |-> $past(in_acc && op_i == pcrll_pkg::OP_RESET))
    else $error("reset counter changed without a forced reset");

endmodule

// ===== hdl/pcrll_mul.sv =====
// shared 32 by 32 unsigned multiplier with registered product
module pcrll_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // one partial product per cycle
  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule
